FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the block clock
`define ECW_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ecw check failed");

// implication in the next cycle
`define ECW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ecw check failed");

`endif

FILE: rtl/ecw_pkg.sv
package ecw_pkg;

   localparam int VERTEX_W    = 8;
   localparam int VERTEX_CAP  = 256;
   localparam int TOTAL_W     = 9;
   localparam int CSR_INDEX_W = 1;

   // item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_NEXT  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL = 1'b1;

   typedef struct packed {
      logic [1:0]          kind;
      logic [VERTEX_W-1:0] end_a;
      logic [VERTEX_W-1:0] end_b;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                final_vertex;
      logic                past_end;
   } rsp_type;

   // one stored edge: endpoints as loaded
   typedef struct packed {
      logic [VERTEX_W-1:0] first;
      logic [VERTEX_W-1:0] second;
   } edge_word_type;

endpackage

FILE: rtl/ecw_ram.sv
module ecw_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ecw_sort.sv
module ecw_sort import ecw_pkg::*; #(
   parameter int MAX_EDGES = 1024,
   localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
   localparam int CNT_W = $clog2(MAX_EDGES + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [CNT_W-1:0] edge_count,
   output logic            done,
   output logic [EA_W-1:0] edge_rd_addr,
   input  edge_word_type   edge_rd_data,
   output logic            edge_wr_en,
   output logic [EA_W-1:0] edge_wr_addr,
   output edge_word_type   edge_wr_data
);

   // two-pass lsd radix sort: by second endpoint into the scratch store,
   // then by first endpoint back into the edge store
   typedef enum logic [3:0] {
      ST_IDLE, ST_CLR, ST_T_RD, ST_T_CNT, ST_T_WR,
      ST_P_RD, ST_P_WR, ST_S_RD, ST_S_CNT, ST_S_WR
   } state_type;

   state_type     state_ff, state_in;
   logic          pass_ff, pass_in;
   logic [CNT_W-1:0] item_ff, item_in;
   logic [8:0]    key_ff, key_in;
   logic [CNT_W-1:0] sum_ff, sum_in;
   edge_word_type word_ff, word_in;
   logic          done_ff, done_in;

   logic          tmp_wr_en;
   edge_word_type tmp_rd_data;
   logic          cnt_wr_en;
   logic [7:0]    cnt_wr_addr;
   logic [CNT_W-1:0] cnt_wr_data;
   logic [7:0]    cnt_rd_addr;
   logic [CNT_W-1:0] cnt_rd_data;

   edge_word_type src_word;
   logic [7:0]    src_digit;
   logic [7:0]    word_digit;

   assign src_word   = pass_ff ? tmp_rd_data : edge_rd_data;
   assign src_digit  = pass_ff ? src_word.first : src_word.second;
   assign word_digit = pass_ff ? word_ff.first : word_ff.second;

   // scratch store for the first pass
   ecw_ram #(.WIDTH($bits(edge_word_type)), .DEPTH(MAX_EDGES), .ADDR_W(EA_W)) u_tmp (
      .clock   (clock),
      .wr_en   (tmp_wr_en),
      .wr_addr (cnt_rd_data[EA_W-1:0]),
      .wr_data (word_ff),
      .rd_addr (item_ff[EA_W-1:0]),
      .rd_data (tmp_rd_data)
   );

   // digit counts, then start offsets
   ecw_ram #(.WIDTH(CNT_W), .DEPTH(256), .ADDR_W(8)) u_cnt (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   assign edge_rd_addr = item_ff[EA_W-1:0];
   assign edge_wr_addr = cnt_rd_data[EA_W-1:0];
   assign edge_wr_data = word_ff;
   assign done         = done_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      item_in     = item_ff;
      key_in      = key_ff;
      sum_in      = sum_ff;
      word_in     = word_ff;
      done_in     = 1'b0;
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = key_ff[7:0];
      cnt_wr_data = '0;
      cnt_rd_addr = key_ff[7:0];
      tmp_wr_en   = 1'b0;
      edge_wr_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               pass_in  = 1'b0;
               key_in   = '0;
               state_in = ST_CLR;
            end
         end
         ST_CLR: begin
            cnt_wr_en = 1'b1;
            key_in    = key_ff + 9'd1;
            if (key_ff[7:0] == 8'hFF) begin
               item_in  = '0;
               state_in = ST_T_RD;
            end
         end
         ST_T_RD: begin
            if (item_ff == edge_count) begin
               key_in   = '0;
               sum_in   = '0;
               state_in = ST_P_RD;
            end else begin
               state_in = ST_T_CNT;
            end
         end
         ST_T_CNT: begin
            word_in     = src_word;
            cnt_rd_addr = src_digit;
            state_in    = ST_T_WR;
         end
         ST_T_WR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = word_digit;
            cnt_wr_data = cnt_rd_data + 1'b1;
            item_in     = item_ff + 1'b1;
            state_in    = ST_T_RD;
         end
         ST_P_RD: begin
            if (key_ff[8]) begin
               item_in  = '0;
               state_in = ST_S_RD;
            end else begin
               state_in = ST_P_WR;
            end
         end
         ST_P_WR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_data = sum_ff;
            sum_in      = sum_ff + cnt_rd_data;
            key_in      = key_ff + 9'd1;
            state_in    = ST_P_RD;
         end
         ST_S_RD: begin
            if (item_ff == edge_count) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  key_in   = '0;
                  state_in = ST_CLR;
               end else begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_S_CNT;
            end
         end
         ST_S_CNT: begin
            word_in     = src_word;
            cnt_rd_addr = src_digit;
            state_in    = ST_S_WR;
         end
         ST_S_WR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = word_digit;
            cnt_wr_data = cnt_rd_data + 1'b1;
            tmp_wr_en   = !pass_ff;
            edge_wr_en  = pass_ff;
            item_in     = item_ff + 1'b1;
            state_in    = ST_S_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      pass_ff <= pass_in;
      item_ff <= item_in;
      key_ff  <= key_in;
      sum_ff  <= sum_in;
      word_ff <= word_in;
   end

endmodule

FILE: rtl/euler_circuit_walker_unit.sv
// load and clear words are taken while idle; busy stays low.
// first request after loading sorts the edges and builds the incidence lists,
// then walks like any request.
// a request pushes unused edges and skips used ones until it pops a vertex
// (the closing vertex ends the walk); the vertex word is registered as it is popped.
// synchronous reset: empty graph, loading phase, start 0, vertex total 256.
module euler_circuit_walker_unit import ecw_pkg::*; #(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req,
   output logic                   rsp_valid,
   output rsp_type                rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TOTAL_W-1:0]     csr_wdata
);

   localparam int EA_W        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W       = $clog2(MAX_EDGES + 1);
   localparam int SLOT_W      = EA_W + 1;
   localparam int LINK_AW     = $clog2(2 * MAX_EDGES);
   localparam int STACK_DEPTH = MAX_EDGES + 1;
   localparam int ST_AW       = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(MAX_EDGES + 2);
   localparam int VCAP        = (MAX_VERTICES < VERTEX_CAP) ? MAX_VERTICES : VERTEX_CAP;

   typedef enum logic [1:0] {PH_LOAD, PH_WALK, PH_DONE} phase_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SORT, S_BNEXT, S_B1, S_B2, S_B3, S_B4,
      S_W_CHK, S_W_HEAD, S_W_LINK, S_W_PUSH, S_W_REFILL
   } state_type;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [VERTEX_W-1:0] sv_ff, sv_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [SP_W-1:0]     depth_ff, depth_in;
   logic [VERTEX_W-1:0] top_ff, top_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   edge_word_type       word_ff, word_in;
   logic [VERTEX_CAP-1:0] hv_ff, hv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // memory ports
   logic          e_wr_en;
   logic [EA_W-1:0] e_wr_addr, e_rd_addr;
   edge_word_type e_wr_data, e_rd_data;
   logic          h_wr_en;
   logic [VERTEX_W-1:0] h_wr_addr, h_rd_addr;
   logic [SLOT_W-1:0]   h_wr_data, h_rd_data;
   logic          l_wr_en;
   logic [LINK_AW-1:0] l_wr_addr, l_rd_addr;
   logic [SLOT_W:0]    l_wr_data, l_rd_data;
   logic          m_wr_en;
   logic [EA_W-1:0] m_wr_addr, m_rd_addr;
   logic          m_wr_data, m_rd_data;
   logic          k_wr_en;
   logic [ST_AW-1:0] k_wr_addr, k_rd_addr;
   logic [VERTEX_W-1:0] k_wr_data, k_rd_data;

   // sorter side of the edge store
   logic          sort_go, sort_done;
   logic [EA_W-1:0] s_rd_addr, s_wr_addr;
   logic          s_wr_en;
   edge_word_type s_wr_data;

   logic          take;
   logic [TOTAL_W-1:0] total_eff;
   logic [TOTAL_W-1:0] start_clip;
   logic [VERTEX_W-1:0] start_eff;
   logic          word_out;
   logic [SLOT_W-1:0] slot_lo, slot_hi;
   logic          link_valid;
   logic [SLOT_W-1:0] link_ptr;
   logic [VERTEX_W-1:0] other_end;

   ecw_sort #(.MAX_EDGES(MAX_EDGES)) u_sort (
      .clock        (clock),
      .reset        (reset),
      .go           (sort_go),
      .edge_count   (count_ff),
      .done         (sort_done),
      .edge_rd_addr (s_rd_addr),
      .edge_rd_data (e_rd_data),
      .edge_wr_en   (s_wr_en),
      .edge_wr_addr (s_wr_addr),
      .edge_wr_data (s_wr_data)
   );

   ecw_ram #(.WIDTH($bits(edge_word_type)), .DEPTH(MAX_EDGES), .ADDR_W(EA_W)) u_edge (
      .clock (clock), .wr_en (e_wr_en), .wr_addr (e_wr_addr), .wr_data (e_wr_data),
      .rd_addr (e_rd_addr), .rd_data (e_rd_data)
   );

   ecw_ram #(.WIDTH(SLOT_W), .DEPTH(VERTEX_CAP), .ADDR_W(VERTEX_W)) u_head (
      .clock (clock), .wr_en (h_wr_en), .wr_addr (h_wr_addr), .wr_data (h_wr_data),
      .rd_addr (h_rd_addr), .rd_data (h_rd_data)
   );

   ecw_ram #(.WIDTH(SLOT_W + 1), .DEPTH(2 * MAX_EDGES), .ADDR_W(LINK_AW)) u_link (
      .clock (clock), .wr_en (l_wr_en), .wr_addr (l_wr_addr), .wr_data (l_wr_data),
      .rd_addr (l_rd_addr), .rd_data (l_rd_data)
   );

   ecw_ram #(.WIDTH(1), .DEPTH(MAX_EDGES), .ADDR_W(EA_W)) u_mark (
      .clock (clock), .wr_en (m_wr_en), .wr_addr (m_wr_addr), .wr_data (m_wr_data),
      .rd_addr (m_rd_addr), .rd_data (m_rd_data)
   );

   ecw_ram #(.WIDTH(VERTEX_W), .DEPTH(STACK_DEPTH), .ADDR_W(ST_AW)) u_stack (
      .clock (clock), .wr_en (k_wr_en), .wr_addr (k_wr_addr), .wr_data (k_wr_data),
      .rd_addr (k_rd_addr), .rd_data (k_rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign take      = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // effective vertex total and start vertex
   always_comb begin
      total_eff = total_ff;
      if (total_eff == '0) begin
         total_eff = TOTAL_W'(1);
      end
      if (total_eff > TOTAL_W'(VCAP)) begin
         total_eff = TOTAL_W'(VCAP);
      end
      start_clip = {1'b0, sv_ff};
      if (start_clip >= total_eff) begin
         start_clip = total_eff - 1'b1;
      end
      start_eff = start_clip[VERTEX_W-1:0];
   end

   assign word_out   = ({1'b0, word_ff.first} >= total_eff) ||
                       ({1'b0, word_ff.second} >= total_eff);
   assign slot_lo    = {idx_ff[EA_W-1:0], 1'b0};
   assign slot_hi    = {idx_ff[EA_W-1:0], 1'b1};
   assign link_valid = l_rd_data[SLOT_W];
   assign link_ptr   = l_rd_data[SLOT_W-1:0];
   assign other_end  = cur_ff[0] ? e_rd_data.first : e_rd_data.second;

   // control: loading, list build, walk
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      sv_in        = sv_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      cur_in       = cur_ff;
      word_in      = word_ff;
      hv_in        = hv_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      sort_go      = 1'b0;

      e_wr_en   = (state_ff == S_SORT) ? s_wr_en : 1'b0;
      e_wr_addr = (state_ff == S_SORT) ? s_wr_addr : count_ff[EA_W-1:0];
      e_wr_data = (state_ff == S_SORT) ? s_wr_data : edge_word_type'{req.end_a, req.end_b};
      e_rd_addr = (state_ff == S_SORT) ? s_rd_addr : idx_ff[EA_W-1:0];
      h_wr_en   = 1'b0;
      h_wr_addr = word_ff.first;
      h_wr_data = slot_lo;
      h_rd_addr = top_ff;
      l_wr_en   = 1'b0;
      l_wr_addr = slot_lo[LINK_AW-1:0];
      l_wr_data = {hv_ff[word_ff.first], h_rd_data};
      l_rd_addr = cur_ff[LINK_AW-1:0];
      m_wr_en   = 1'b0;
      m_wr_addr = idx_ff[EA_W-1:0];
      m_wr_data = 1'b0;
      m_rd_addr = cur_ff[SLOT_W-1:1];
      k_wr_en   = 1'b0;
      k_wr_addr = depth_ff[ST_AW-1:0];
      k_wr_data = start_eff;
      k_rd_addr = ST_AW'(depth_ff - 2'd2);

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_START: sv_in    = csr_wdata[VERTEX_W-1:0];
            CSR_TOTAL: total_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               unique case (req.kind)
                  KIND_LOAD: begin
                     if (phase_ff == PH_LOAD && count_ff < CNT_W'(MAX_EDGES)) begin
                        e_wr_en  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_NEXT: begin
                     unique case (phase_ff)
                        PH_LOAD: begin
                           sort_go  = 1'b1;
                           hv_in    = '0;
                           state_in = S_SORT;
                        end
                        PH_WALK: state_in = S_W_CHK;
                        default: begin
                           rsp_valid_in = 1'b1;
                           rsp_in = '{vertex: '0, final_vertex: 1'b0, past_end: 1'b1};
                        end
                     endcase
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     depth_in = '0;
                     phase_in = PH_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         S_SORT: begin
            if (sort_done) begin
               idx_in   = '0;
               state_in = S_BNEXT;
            end
         end
         // list build, one sorted edge at a time
         S_BNEXT: begin
            if (idx_ff == count_ff) begin
               k_wr_en   = 1'b1;
               k_wr_addr = '0;
               depth_in  = SP_W'(1);
               top_in    = start_eff;
               phase_in  = PH_WALK;
               state_in  = S_W_CHK;
            end else begin
               m_wr_en  = 1'b1;
               state_in = S_B1;
            end
         end
         S_B1: begin
            word_in = e_rd_data;
            if (({1'b0, e_rd_data.first} >= total_eff) ||
                ({1'b0, e_rd_data.second} >= total_eff)) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_BNEXT;
            end else begin
               h_rd_addr = e_rd_data.first;
               state_in  = S_B2;
            end
         end
         S_B2: begin
            l_wr_en  = !word_out;
            h_wr_en  = !word_out;
            hv_in[word_ff.first] = 1'b1;
            state_in = S_B3;
         end
         S_B3: begin
            h_rd_addr = word_ff.second;
            state_in  = S_B4;
         end
         S_B4: begin
            l_wr_en   = 1'b1;
            l_wr_addr = slot_hi[LINK_AW-1:0];
            l_wr_data = {hv_ff[word_ff.second], h_rd_data};
            h_wr_en   = 1'b1;
            h_wr_addr = word_ff.second;
            h_wr_data = slot_hi;
            hv_in[word_ff.second] = 1'b1;
            idx_in    = idx_ff + 1'b1;
            state_in  = S_BNEXT;
         end
         // walk: pop when the top vertex has no edge left
         S_W_CHK: begin
            if (!hv_ff[top_ff]) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{vertex: top_ff, final_vertex: (depth_ff == SP_W'(1)),
                          past_end: 1'b0};
               depth_in = depth_ff - 1'b1;
               if (depth_ff == SP_W'(1)) begin
                  phase_in = PH_DONE;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_W_REFILL;
               end
            end else begin
               state_in = S_W_HEAD;
            end
         end
         S_W_HEAD: begin
            cur_in    = h_rd_data;
            l_rd_addr = h_rd_data[LINK_AW-1:0];
            m_rd_addr = h_rd_data[SLOT_W-1:1];
            state_in  = S_W_LINK;
         end
         S_W_LINK: begin
            h_wr_en   = 1'b1;
            h_wr_addr = top_ff;
            h_wr_data = link_ptr;
            hv_in[top_ff] = link_valid;
            if (m_rd_data) begin
               if (link_valid) begin
                  cur_in    = link_ptr;
                  l_rd_addr = link_ptr[LINK_AW-1:0];
                  m_rd_addr = link_ptr[SLOT_W-1:1];
               end else begin
                  state_in = S_W_CHK;
               end
            end else begin
               m_wr_en   = 1'b1;
               m_wr_addr = cur_ff[SLOT_W-1:1];
               m_wr_data = 1'b1;
               e_rd_addr = cur_ff[SLOT_W-1:1];
               state_in  = S_W_PUSH;
            end
         end
         S_W_PUSH: begin
            if (depth_ff < SP_W'(STACK_DEPTH)) begin
               k_wr_en   = 1'b1;
               k_wr_data = other_end;
               depth_in  = depth_ff + 1'b1;
               top_in    = other_end;
            end
            state_in = S_W_CHK;
         end
         S_W_REFILL: begin
            top_in   = k_rd_data;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LOAD;
         sv_ff        <= '0;
         total_ff     <= TOTAL_W'(256);
         count_ff     <= '0;
         depth_ff     <= '0;
         hv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sv_ff        <= sv_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         hv_ff        <= hv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      top_ff  <= top_in;
      cur_ff  <= cur_in;
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

`include "assert_macros.svh"

   // a past-end word only after the circuit is complete
   `ECW_ASSERT_NOW(a_past_end_done, rsp_valid_ff && rsp_ff.past_end, phase_ff == PH_DONE)
   // the closing vertex empties the stack
   `ECW_ASSERT_NOW(a_final, rsp_valid_ff && rsp_ff.final_vertex, ~|depth_ff && phase_ff == PH_DONE)
   // a request before the end starts the sort or the walk
   `ECW_ASSERT_NEXT(a_walk_busy, take && req.kind == KIND_NEXT && phase_ff != PH_DONE, busy)

endmodule
